// ===== src/mh2_pkg.sv =====
// mh2_pkg: constants, multiplier op codes and controller/datapath bundles
// for the murmur2 hash engine; no dependencies
`default_nettype none

package mh2_pkg;

    localparam logic [31:0] MIX_MULT    = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;
    localparam logic [31:0] SEED_RESET  = 32'd97;
    localparam logic [2:0]  FULL_BYTES  = 3'd4;

    // which operand goes into the shared multiplier and where the product lands
    typedef enum logic [2:0] {
        MUL_K_FIRST  = 3'd0,
        MUL_K_SECOND = 3'd1,
        MUL_H_FOLD   = 3'd2,
        MUL_H_TAIL   = 3'd3,
        MUL_H_FIN    = 3'd4
    } t_mul_op;

    typedef struct packed {
        logic    load;      // capture chunk and set up accumulator
        logic    resume;    // key already open: keep accumulator
        logic    mul_en;    // run the multiplier this cycle
        t_mul_op op;
        logic    out_load;  // write finished hash to output register
    } t_dp_cmd;

    typedef struct packed {
        logic full_chunk;   // incoming chunk takes the full mix path
        logic tail_empty;   // incoming last chunk carries no bytes
        logic last;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== src/mh2_chunk_if.sv =====
// mh2_chunk_if: valid/ready channel carrying key chunks into the engine
// no dependencies
`default_nettype none

interface mh2_chunk_if;
    logic        valid;
    logic        ready;
    logic [31:0] chunk_data;
    logic [2:0]  chunk_bytes;
    logic [30:0] key_length;
    logic        last_chunk;

    modport source (output valid, chunk_data, chunk_bytes, key_length, last_chunk,
                    input ready);
    modport sink   (input valid, chunk_data, chunk_bytes, key_length, last_chunk,
                    output ready);
endinterface

`default_nettype wire

// ===== src/mh2_hash_if.sv =====
// mh2_hash_if: valid/ready channel carrying finished hash values
// no dependencies
`default_nettype none

interface mh2_hash_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

`default_nettype wire

// ===== src/murmur2_hash_engine.sv =====
// murmur2_hash_engine: top level, 32-bit murmur2 hash over streamed key chunks
// uses mh2_pkg, mh2_chunk_if, mh2_hash_if, mh2_ctrl, mh2_datapath
//
//   channel   dir  handshake        payload
//   i_chunk   in   valid/ready      chunk_data, chunk_bytes, key_length, last_chunk
//   o_hash    out  valid/ready      hash_value
//   seed      in   i_hash_seed_we   i_hash_seed (32 bit)
//
// one chunk at a time through a single 32x32 constant multiplier:
// a non-last or four-byte chunk is accepted, then takes three multiplies;
// a last chunk of 1-3 bytes takes one tail multiply instead, an empty one none;
// every last chunk then takes one finalize multiply and loads the output register.
// output register lets the next key start while a hash waits for transfer;
// a finished hash stalls only if the previous one is still unclaimed.
// synchronous active-low reset; seed resets to 97
`default_nettype none

module murmur2_hash_engine
    import mh2_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    mh2_chunk_if.sink        i_chunk,
    mh2_hash_if.source       o_hash,
    input  wire logic        i_hash_seed_we,
    input  wire logic [31:0] i_hash_seed
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;
    logic       w_out_valid;
    logic [31:0] w_hash_value;

    mh2_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_chunk.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_hash.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    mh2_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seed_we     (i_hash_seed_we),
        .i_seed        (i_hash_seed),
        .i_chunk_data  (i_chunk.chunk_data),
        .i_chunk_bytes (i_chunk.chunk_bytes),
        .i_key_length  (i_chunk.key_length),
        .i_last_chunk  (i_chunk.last_chunk),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_hash_value  (w_hash_value)
    );

    assign i_chunk.ready     = w_in_ready;
    assign o_hash.valid      = w_out_valid;
    assign o_hash.hash_value = w_hash_value;

`ifndef ASSERT_OFF
    // a last chunk needs at least a finalize step before the next transfer
    a_last_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_chunk.valid && i_chunk.ready && i_chunk.last_chunk) |=> !i_chunk.ready)
        else $error("input taken right after a last chunk");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_hash.valid || o_hash.ready))
        else $error("output register overwritten before transfer");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_hash.valid) |-> $past(w_cmd.out_load))
        else $error("hash valid without an output load");

    a_valid_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hash.valid && o_hash.ready && !w_cmd.out_load) |=> !o_hash.valid)
        else $error("hash repeated after transfer");
`endif

endmodule

`default_nettype wire

// ===== src/mh2_datapath.sv =====
// mh2_datapath: seed register, chunk and accumulator registers, one shared
// 32x32 constant multiplier and the output register; uses mh2_pkg
`default_nettype none

module mh2_datapath
    import mh2_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_seed_we,
    input  wire logic [31:0] i_seed,
    input  wire logic [31:0] i_chunk_data,
    input  wire logic [2:0]  i_chunk_bytes,
    input  wire logic [30:0] i_key_length,
    input  wire logic        i_last_chunk,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_status       o_status,
    output logic [31:0]      o_hash_value
);

    logic [31:0] r_seed;
    logic [31:0] r_k;
    logic [31:0] r_h;
    logic [2:0]  r_bytes;
    logic [31:0] r_out;
    logic [31:0] w_tail_mask;
    logic [31:0] w_mul_a;
    logic [31:0] w_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_seed_we) begin
            r_seed <= i_seed;
        end
    end

    always_comb begin
        o_status.last       = i_last_chunk;
        o_status.full_chunk = !i_last_chunk || (i_chunk_bytes >= FULL_BYTES);
        o_status.tail_empty = (i_chunk_bytes == 3'd0);
    end

    always_comb begin
        if (r_bytes >= 3'd3) begin
            w_tail_mask = 32'h00ffffff;
        end else if (r_bytes == 3'd2) begin
            w_tail_mask = 32'h0000ffff;
        end else begin
            w_tail_mask = 32'h000000ff;
        end
    end

    always_comb begin
        case (i_cmd.op)
            MUL_K_FIRST:  w_mul_a = r_k;
            MUL_K_SECOND: w_mul_a = r_k ^ (r_k >> MIX_SHIFT);
            MUL_H_FOLD:   w_mul_a = r_h;
            MUL_H_TAIL:   w_mul_a = r_h ^ (r_k & w_tail_mask);
            MUL_H_FIN:    w_mul_a = r_h ^ (r_h >> FIN_SHIFT_A);
            default:      w_mul_a = r_h;
        endcase
    end

    assign w_prod = w_mul_a * MIX_MULT;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_k     <= i_chunk_data;
            r_bytes <= i_chunk_bytes;
            if (!i_cmd.resume) begin
                r_h <= r_seed ^ {1'b0, i_key_length};
            end
        end else if (i_cmd.mul_en) begin
            case (i_cmd.op)
                MUL_K_FIRST:  r_k <= w_prod;
                MUL_K_SECOND: r_k <= w_prod;
                MUL_H_FOLD:   r_h <= w_prod ^ r_k;
                MUL_H_TAIL:   r_h <= w_prod;
                MUL_H_FIN:    r_h <= w_prod;
                default:      r_h <= r_h;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out <= r_h ^ (r_h >> FIN_SHIFT_B);
        end
    end

    assign o_hash_value = r_out;

endmodule

`default_nettype wire

// ===== src/mh2_ctrl.sv =====
// mh2_ctrl: one-hot sequencer for chunk mixing, tail, finalization and
// output handoff; uses mh2_pkg
`default_nettype none

module mh2_ctrl
    import mh2_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MK1  = 7'b0000010,
        S_MK2  = 7'b0000100,
        S_MH   = 7'b0001000,
        S_MT   = 7'b0010000,
        S_MF   = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_key_open, n_key_open;
    logic   r_last, n_last;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_key_open  = r_key_open;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '{load: 1'b0, resume: r_key_open, mul_en: 1'b0,
                        op: MUL_H_FOLD, out_load: 1'b0};
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_last     = i_status.last;
                    if (i_status.full_chunk) begin
                        n_state = S_MK1;
                    end else if (!i_status.tail_empty) begin
                        n_state = S_MT;
                    end else begin
                        n_state = S_MF;
                    end
                end
            end
            S_MK1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = MUL_K_FIRST;
                n_state      = S_MK2;
            end
            S_MK2: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = MUL_K_SECOND;
                n_state      = S_MH;
            end
            S_MH: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = MUL_H_FOLD;
                if (r_last) begin
                    n_state = S_MF;
                end else begin
                    n_key_open = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_MT: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = MUL_H_TAIL;
                n_state      = S_MF;
            end
            S_MF: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = MUL_H_FIN;
                n_state      = S_OUT;
            end
            S_OUT: begin
                // wait here only while the previous hash is still unclaimed
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_key_open     = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key_open  <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_key_open  <= n_key_open;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire
